// ===== rtl/windowed_angle_average_framer_macros.svh =====
// Assertion helpers for the windowed angle average framer.
// Both forms sample on the rising edge of clock and are disabled during reset.
`ifndef WINDOWED_ANGLE_AVERAGE_FRAMER_MACROS_SVH
`define WINDOWED_ANGLE_AVERAGE_FRAMER_MACROS_SVH

`ifndef SYNTHESIS

`define WAAF_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define WAAF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define WAAF_ASSERT_ALWAYS(label, cond, msg)

`define WAAF_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/waaf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package waaf_pkg;

   localparam int WINDOW    = 10;
   localparam int ANGLE_W   = 17;
   localparam int THRESH_W  = 16;
   localparam int BYTE_W    = 8;
   localparam int SCALED_W  = 16;

   // Slot index, fill count (must hold WINDOW itself) and running sum widths.
   localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W     = $clog2(WINDOW + 1);
   localparam int SUM_W     = ANGLE_W + $clog2(WINDOW);
   // floor(|sum| * 100 / 256) needs one bit less than the sum.
   localparam int DIV_W     = SUM_W - 1;
   localparam int DCNT_W    = $clog2(DIV_W + 1);
   localparam int ENTRY_W   = 2 * ANGLE_W;

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(7680);
   localparam logic [6:0]          SCALE_HUNDREDTHS = 7'd100;
   localparam int                  FRAC_BITS = 8;

   localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'hFF;
   localparam logic [BYTE_W-1:0] GESTURE_BYTE = 8'hFE;

   // Byte positions within a frame.
   localparam logic [2:0] POS_SYNC     = 3'd0;
   localparam logic [2:0] POS_ROLL_LO  = 3'd1;
   localparam logic [2:0] POS_ROLL_HI  = 3'd2;
   localparam logic [2:0] POS_PITCH_LO = 3'd3;
   localparam logic [2:0] POS_PITCH_HI = 3'd4;
   localparam logic [2:0] POS_GESTURE  = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_SUM  = 5'b00100,
      ST_MAG  = 5'b01000,
      ST_DIV  = 5'b10000
   } state_type;

   typedef struct packed {
      logic                load;
      logic [SCALED_W-1:0] roll_scaled;
      logic [SCALED_W-1:0] pitch_scaled;
      logic                gesture;
   } frame_load_type;

endpackage

`default_nettype wire

// ===== rtl/waaf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface waaf_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [waaf_pkg::ANGLE_W-1:0] roll_angle;
   logic signed [waaf_pkg::ANGLE_W-1:0] pitch_angle;

   modport source (output valid, output roll_angle, output pitch_angle, input ready);
   modport sink (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

interface waaf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [waaf_pkg::BYTE_W-1:0]        frame_byte;
   logic                               frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/waaf_window_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module waaf_window_ram #(
   parameter int WIDTH  = 34,
   parameter int DEPTH  = 10,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/waaf_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module waaf_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [waaf_pkg::DIV_W-1:0]  dividend,
   input  wire logic [waaf_pkg::CNT_W-1:0]  divisor,
   output logic                             done,
   output logic [waaf_pkg::DIV_W-1:0]       quotient
);

   logic [waaf_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [waaf_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [waaf_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [waaf_pkg::CNT_W:0]    rem_shift;

   always_comb begin
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = done_ff;
      rem_shift = {rem_ff, quo_ff[waaf_pkg::DIV_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = waaf_pkg::DCNT_W'(waaf_pkg::DIV_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // The dividend shifts out at the top while quotient bits enter at the bottom.
         if (rem_shift >= {1'b0, divisor}) begin
            rem_in = waaf_pkg::CNT_W'(rem_shift - {1'b0, divisor});
            quo_in = {quo_ff[waaf_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[waaf_pkg::CNT_W-1:0];
            quo_in = {quo_ff[waaf_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == waaf_pkg::DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/waaf_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Holds one finished frame and sends it byte by byte.
module waaf_framer (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire waaf_pkg::frame_load_type frame,
   output logic                          busy,
   waaf_rsp_if.source                    rsp
);

   logic                              busy_ff, busy_in;
   logic [2:0]                        pos_ff, pos_in;
   logic [waaf_pkg::SCALED_W-1:0]     roll_ff, roll_in;
   logic [waaf_pkg::SCALED_W-1:0]     pitch_ff, pitch_in;
   logic                              gesture_ff, gesture_in;
   logic [2:0]                        last_pos;
   logic                              xfer;

   assign last_pos = gesture_ff ? waaf_pkg::POS_GESTURE : waaf_pkg::POS_PITCH_HI;
   assign xfer     = rsp.valid && rsp.ready;

   always_comb begin
      busy_in    = busy_ff;
      pos_in     = pos_ff;
      roll_in    = roll_ff;
      pitch_in   = pitch_ff;
      gesture_in = gesture_ff;
      if (frame.load) begin
         busy_in    = 1'b1;
         pos_in     = waaf_pkg::POS_SYNC;
         roll_in    = frame.roll_scaled;
         pitch_in   = frame.pitch_scaled;
         gesture_in = frame.gesture;
      end else if (xfer) begin
         if (pos_ff == last_pos) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      roll_ff    <= roll_in;
      pitch_ff   <= pitch_in;
      gesture_ff <= gesture_in;
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= waaf_pkg::POS_SYNC;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_comb begin
      unique case (pos_ff)
         waaf_pkg::POS_SYNC:     rsp.frame_byte = waaf_pkg::SYNC_BYTE;
         waaf_pkg::POS_ROLL_LO:  rsp.frame_byte = roll_ff[7:0];
         waaf_pkg::POS_ROLL_HI:  rsp.frame_byte = roll_ff[15:8];
         waaf_pkg::POS_PITCH_LO: rsp.frame_byte = pitch_ff[7:0];
         waaf_pkg::POS_PITCH_HI: rsp.frame_byte = pitch_ff[15:8];
         default:                rsp.frame_byte = waaf_pkg::GESTURE_BYTE;
      endcase
   end

   assign rsp.valid     = busy_ff;
   assign rsp.frame_end = (pos_ff == last_pos);
   assign busy          = busy_ff;

endmodule

`default_nettype wire

// ===== rtl/windowed_angle_average_framer.sv =====
// An input transfer passes through the read, sum and magnitude states, then waits in the
// divide state for the bit-serial divide by the fill count before its frame is loaded.
// Items are taken one at a time; a frame is 5 or 6 output transfers, the next item is taken
// while a frame drains, and a finished divide waits until the framer is free.
// Reset (synchronous, active high) empties the window, clears sums and sets the threshold
// to 7680; window memory contents are not cleared and are never read before written.
`timescale 1ns / 1ps
`default_nettype none

`include "windowed_angle_average_framer_macros.svh"

module windowed_angle_average_framer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [waaf_pkg::THRESH_W-1:0] csr_wr_data,
   waaf_req_if.sink                           req,
   waaf_rsp_if.source                         rsp
);

   waaf_pkg::state_type state_ff, state_in;

   logic [waaf_pkg::THRESH_W-1:0]      thresh_ff, thresh_in;
   logic [waaf_pkg::SLOT_W-1:0]        slot_ff, slot_in;
   logic [waaf_pkg::CNT_W-1:0]         count_ff, count_in;
   logic signed [waaf_pkg::SUM_W-1:0]  roll_sum_ff, roll_sum_in;
   logic signed [waaf_pkg::SUM_W-1:0]  pitch_sum_ff, pitch_sum_in;
   logic signed [waaf_pkg::ANGLE_W-1:0] roll_new_ff, roll_new_in;
   logic signed [waaf_pkg::ANGLE_W-1:0] pitch_new_ff, pitch_new_in;
   logic                               roll_neg_ff, roll_neg_in;
   logic                               pitch_neg_ff, pitch_neg_in;
   logic                               gesture_ff, gesture_in;

   logic [waaf_pkg::ENTRY_W-1:0]       rd_entry;
   logic signed [waaf_pkg::ANGLE_W-1:0] roll_old;
   logic signed [waaf_pkg::ANGLE_W-1:0] pitch_old;
   logic                               wr_en;
   logic                               full;

   logic [waaf_pkg::SUM_W-1:0]         roll_mag;
   logic [waaf_pkg::SUM_W-1:0]         pitch_mag;
   logic [waaf_pkg::SUM_W+6:0]         roll_x100;
   logic [waaf_pkg::SUM_W+6:0]         pitch_x100;
   logic [waaf_pkg::THRESH_W+waaf_pkg::CNT_W-1:0] thresh_scaled;

   logic                               div_start;
   logic                               roll_done;
   logic                               pitch_done;
   logic [waaf_pkg::DIV_W-1:0]         roll_quo;
   logic [waaf_pkg::DIV_W-1:0]         pitch_quo;
   logic [waaf_pkg::SCALED_W-1:0]      roll_q16;
   logic [waaf_pkg::SCALED_W-1:0]      pitch_q16;

   waaf_pkg::frame_load_type           frame;
   logic                               framer_busy;

   assign full      = (count_ff == waaf_pkg::CNT_W'(waaf_pkg::WINDOW));
   assign roll_old  = rd_entry[waaf_pkg::ENTRY_W-1:waaf_pkg::ANGLE_W];
   assign pitch_old = rd_entry[waaf_pkg::ANGLE_W-1:0];
   assign req.ready = (state_ff == waaf_pkg::ST_IDLE);

   assign roll_mag   = roll_sum_ff[waaf_pkg::SUM_W-1] ?
                       waaf_pkg::SUM_W'(-roll_sum_ff) : waaf_pkg::SUM_W'(roll_sum_ff);
   assign pitch_mag  = pitch_sum_ff[waaf_pkg::SUM_W-1] ?
                       waaf_pkg::SUM_W'(-pitch_sum_ff) : waaf_pkg::SUM_W'(pitch_sum_ff);
   assign roll_x100  = (waaf_pkg::SUM_W+7)'(roll_mag) * waaf_pkg::SCALE_HUNDREDTHS;
   assign pitch_x100 = (waaf_pkg::SUM_W+7)'(pitch_mag) * waaf_pkg::SCALE_HUNDREDTHS;
   assign thresh_scaled = (waaf_pkg::THRESH_W+waaf_pkg::CNT_W)'(thresh_ff) * count_ff;

   assign roll_q16  = roll_neg_ff ? waaf_pkg::SCALED_W'(-roll_quo[waaf_pkg::SCALED_W-1:0])
                                  : roll_quo[waaf_pkg::SCALED_W-1:0];
   assign pitch_q16 = pitch_neg_ff ? waaf_pkg::SCALED_W'(-pitch_quo[waaf_pkg::SCALED_W-1:0])
                                   : pitch_quo[waaf_pkg::SCALED_W-1:0];

   always_comb begin
      state_in     = state_ff;
      thresh_in    = thresh_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      roll_sum_in  = roll_sum_ff;
      pitch_sum_in = pitch_sum_ff;
      roll_new_in  = roll_new_ff;
      pitch_new_in = pitch_new_ff;
      roll_neg_in  = roll_neg_ff;
      pitch_neg_in = pitch_neg_ff;
      gesture_in   = gesture_ff;
      wr_en        = 1'b0;
      div_start    = 1'b0;
      frame.load         = 1'b0;
      frame.roll_scaled  = roll_q16;
      frame.pitch_scaled = pitch_q16;
      frame.gesture      = gesture_ff;

      if (csr_wr_en) begin
         thresh_in = csr_wr_data;
      end

      unique case (state_ff)
         waaf_pkg::ST_IDLE: begin
            if (req.valid) begin
               roll_new_in  = req.roll_angle;
               pitch_new_in = req.pitch_angle;
               state_in     = waaf_pkg::ST_READ;
            end
         end
         waaf_pkg::ST_READ: begin
            // The entry at the write slot is on its way out of the memory.
            state_in = waaf_pkg::ST_SUM;
         end
         waaf_pkg::ST_SUM: begin
            // Running sums: add the new sample, drop the one it replaces once full.
            wr_en        = 1'b1;
            roll_sum_in  = roll_sum_ff + waaf_pkg::SUM_W'(roll_new_ff)
                           - (full ? waaf_pkg::SUM_W'(roll_old) : '0);
            pitch_sum_in = pitch_sum_ff + waaf_pkg::SUM_W'(pitch_new_ff)
                           - (full ? waaf_pkg::SUM_W'(pitch_old) : '0);
            slot_in  = (slot_ff == waaf_pkg::SLOT_W'(waaf_pkg::WINDOW - 1)) ?
                       '0 : slot_ff + 1'b1;
            if (!full) begin
               count_in = count_ff + 1'b1;
            end
            state_in = waaf_pkg::ST_MAG;
         end
         waaf_pkg::ST_MAG: begin
            roll_neg_in  = roll_sum_ff[waaf_pkg::SUM_W-1];
            pitch_neg_in = pitch_sum_ff[waaf_pkg::SUM_W-1];
            gesture_in   = ((waaf_pkg::THRESH_W+waaf_pkg::CNT_W)'(pitch_mag) > thresh_scaled);
            div_start    = 1'b1;
            state_in     = waaf_pkg::ST_DIV;
         end
         waaf_pkg::ST_DIV: begin
            if (roll_done && pitch_done && !framer_busy) begin
               frame.load = 1'b1;
               state_in   = waaf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = waaf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      roll_new_ff  <= roll_new_in;
      pitch_new_ff <= pitch_new_in;
      roll_neg_ff  <= roll_neg_in;
      pitch_neg_ff <= pitch_neg_in;
      gesture_ff   <= gesture_in;
      if (reset) begin
         state_ff     <= waaf_pkg::ST_IDLE;
         thresh_ff    <= waaf_pkg::THRESH_RESET;
         slot_ff      <= '0;
         count_ff     <= '0;
         roll_sum_ff  <= '0;
         pitch_sum_ff <= '0;
      end else begin
         state_ff     <= state_in;
         thresh_ff    <= thresh_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         roll_sum_ff  <= roll_sum_in;
         pitch_sum_ff <= pitch_sum_in;
      end
   end

   waaf_window_ram #(
      .WIDTH  (waaf_pkg::ENTRY_W),
      .DEPTH  (waaf_pkg::WINDOW),
      .ADDR_W (waaf_pkg::SLOT_W)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data ({roll_new_ff, pitch_new_ff}),
      .rd_addr (slot_ff),
      .rd_data (rd_entry)
   );

   // Dividend is floor(|sum| * 100 / 256); dividing that by the count gives the exact result.
   waaf_divider u_roll_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (roll_x100[waaf_pkg::SUM_W+6:waaf_pkg::FRAC_BITS]),
      .divisor  (count_ff),
      .done     (roll_done),
      .quotient (roll_quo)
   );

   waaf_divider u_pitch_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pitch_x100[waaf_pkg::SUM_W+6:waaf_pkg::FRAC_BITS]),
      .divisor  (count_ff),
      .done     (pitch_done),
      .quotient (pitch_quo)
   );

   waaf_framer u_framer (
      .clock (clock),
      .reset (reset),
      .frame (frame),
      .busy  (framer_busy),
      .rsp   (rsp)
   );

   `WAAF_ASSERT_ALWAYS(a_count_bound, count_ff <= waaf_pkg::CNT_W'(waaf_pkg::WINDOW), "fill count beyond window")
   `WAAF_ASSERT_ALWAYS(a_load_when_free, !frame.load || !framer_busy, "frame loaded while framer busy")
   `WAAF_ASSERT_NEXT(a_accept_reads, req.valid && req.ready, state_ff == waaf_pkg::ST_READ, "transfer did not start a window read")
   `WAAF_ASSERT_NEXT(a_sum_writes, state_ff == waaf_pkg::ST_SUM, count_ff != '0, "window update left the count at zero")

endmodule

`default_nettype wire

// ===== dv/waaf_frame_checker.sv =====
`timescale 1ns / 1ps

module waaf_frame_checker
   import waaf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [THRESH_W-1:0] csr_wr_data,
   waaf_req_if                      req_mon,
   waaf_rsp_if                      rsp_mon,
   output int                       mismatch_count,
   output int                       bytes_outstanding
);

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              frame_end;
   } frame_beat_type;

   frame_beat_type              expected_bytes[$];
   logic signed [ANGLE_W-1:0]   roll_hist [WINDOW];
   logic signed [ANGLE_W-1:0]   pitch_hist [WINDOW];
   int                          write_slot;
   int                          fill_count;
   logic [THRESH_W-1:0]         gesture_limit;
   int                          errors;

   // Average in hundredths of a degree, truncated toward zero, as 16-bit two's complement.
   function automatic logic [SCALED_W-1:0] to_hundredths(input longint total, input int count);
      longint              mag;
      longint              quotient;
      logic [SCALED_W-1:0] result;
      mag      = (total < 0) ? -total : total;
      quotient = (mag * 100) / (longint'(count) * 256);
      result   = quotient[SCALED_W-1:0];
      if (total < 0) begin
         result = -result;
      end
      return result;
   endfunction

   task automatic predict_frame(input logic signed [ANGLE_W-1:0] roll,
                                input logic signed [ANGLE_W-1:0] pitch);
      longint              roll_total;
      longint              pitch_total;
      longint              pitch_mag;
      logic [SCALED_W-1:0] roll_hund;
      logic [SCALED_W-1:0] pitch_hund;
      logic                gesture;
      roll_hist[write_slot]  = roll;
      pitch_hist[write_slot] = pitch;
      write_slot = (write_slot == WINDOW - 1) ? 0 : write_slot + 1;
      if (fill_count < WINDOW) begin
         fill_count++;
      end
      roll_total  = 0;
      pitch_total = 0;
      // While the window fills, the valid entries are exactly the first fill_count slots.
      for (int i = 0; i < fill_count; i++) begin
         roll_total  += roll_hist[i];
         pitch_total += pitch_hist[i];
      end
      roll_hund  = to_hundredths(roll_total, fill_count);
      pitch_hund = to_hundredths(pitch_total, fill_count);
      pitch_mag  = (pitch_total < 0) ? -pitch_total : pitch_total;
      gesture    = pitch_mag > longint'(gesture_limit) * fill_count;
      expected_bytes.push_back('{SYNC_BYTE, 1'b0});
      expected_bytes.push_back('{roll_hund[7:0], 1'b0});
      expected_bytes.push_back('{roll_hund[15:8], 1'b0});
      expected_bytes.push_back('{pitch_hund[7:0], 1'b0});
      expected_bytes.push_back('{pitch_hund[15:8], !gesture});
      if (gesture) begin
         expected_bytes.push_back('{GESTURE_BYTE, 1'b1});
      end
   endtask

   always @(posedge clock) begin
      frame_beat_type wanted;
      if (reset) begin
         expected_bytes.delete();
         write_slot    = 0;
         fill_count    = 0;
         gesture_limit = THRESH_RESET;
      end else begin
         if (csr_wr_en) begin
            gesture_limit = csr_wr_data;
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_frame(req_mon.roll_angle, req_mon.pitch_angle);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_bytes.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("unexpected frame byte %02h end %0b", rsp_mon.frame_byte,
                           rsp_mon.frame_end);
               end
            end else begin
               wanted = expected_bytes.pop_front();
               if (rsp_mon.frame_byte !== wanted.frame_byte ||
                   rsp_mon.frame_end !== wanted.frame_end) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("frame mismatch: byte exp %02h got %02h, end exp %0b got %0b",
                              wanted.frame_byte, rsp_mon.frame_byte, wanted.frame_end,
                              rsp_mon.frame_end);
                  end
               end
            end
         end
      end
      // Published with nonblocking updates so the stimulus side sees settled counts.
      mismatch_count    <= errors;
      bytes_outstanding <= expected_bytes.size();
   end

endmodule

// ===== dv/tb_windowed_angle_average_framer.sv =====
`timescale 1ns / 1ps

module tb_windowed_angle_average_framer;
   import waaf_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 88;
   localparam int ANGLE_MAX     = 46080;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [THRESH_W-1:0]        csr_wr_data = '0;
   logic                       req_valid_drv = 1'b0;
   logic signed [ANGLE_W-1:0]  req_roll_drv = '0;
   logic signed [ANGLE_W-1:0]  req_pitch_drv = '0;
   logic                       rsp_ready_drv = 1'b0;

   int                         idle_pct = 0;
   int                         stall_pct = 0;
   int                         hold_requests = 0;
   int                         hold_served = 0;
   int                         hold_left = 0;
   int                         quiet_cycles = 0;
   int                         mismatch_count;
   int                         bytes_outstanding;
   logic [THRESH_W-1:0]        limit_now = THRESH_RESET;

   waaf_req_if req_ch ();
   waaf_rsp_if rsp_ch ();

   assign req_ch.valid       = req_valid_drv;
   assign req_ch.roll_angle  = req_roll_drv;
   assign req_ch.pitch_angle = req_pitch_drv;
   assign rsp_ch.ready       = rsp_ready_drv;

   windowed_angle_average_framer u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch)
   );

   waaf_frame_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_mon           (req_ch),
      .rsp_mon           (rsp_ch),
      .mismatch_count    (mismatch_count),
      .bytes_outstanding (bytes_outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result sink: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready_drv <= 1'b0;
      end else begin
         rsp_ready_drv <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic logic signed [ANGLE_W-1:0] pick_angle(input logic [THRESH_W-1:0] limit);
      int mode;
      int value;
      mode = $urandom_range(99);
      if (mode < 60) begin
         value = int'($urandom_range(2 * ANGLE_MAX)) - ANGLE_MAX;
      end else if (mode < 75) begin
         value = ANGLE_MAX - int'($urandom_range(1));
      end else if (mode < 90) begin
         value = int'($urandom_range(300));
      end else begin
         value = int'(limit) + int'($urandom_range(4)) - 2;
         if (value > ANGLE_MAX) begin
            value = ANGLE_MAX;
         end
         if (value < 0) begin
            value = 0;
         end
      end
      if ($urandom_range(1) == 1) begin
         value = -value;
      end
      return ANGLE_W'(value);
   endfunction

   // Called right after a rising edge; returns at the edge where the transfer happens.
   task automatic send_angles(input logic signed [ANGLE_W-1:0] roll,
                              input logic signed [ANGLE_W-1:0] pitch);
      while ($urandom_range(99) < idle_pct) begin
         req_valid_drv <= 1'b0;
         @(posedge clock);
      end
      req_valid_drv <= 1'b1;
      req_roll_drv  <= roll;
      req_pitch_drv <= pitch;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid_drv <= 1'b0;
      @(posedge clock);
      while (bytes_outstanding != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [THRESH_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      limit_now    = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input logic [THRESH_W-1:0] limit, input int sender_idle,
                               input int sink_stall, input bit with_hold);
      write_limit(limit);
      idle_pct  = sender_idle;
      stall_pct = sink_stall;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (with_hold && i == 20) begin
            hold_requests++;
         end
         send_angles(pick_angle(limit_now), pick_angle(limit_now));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes while the window is still filling, at the reset threshold.
      send_angles(ANGLE_W'(ANGLE_MAX), ANGLE_W'(ANGLE_MAX));
      send_angles(ANGLE_W'(-ANGLE_MAX), ANGLE_W'(-ANGLE_MAX));
      send_angles('0, '0);
      send_angles(ANGLE_W'(-1), ANGLE_W'(-1));
      send_angles(ANGLE_W'(1), -ANGLE_W'(ANGLE_MAX));
      send_angles(ANGLE_W'(-65536), ANGLE_W'(65535));

      // Full window at exactly the threshold, then one count above it.
      for (int i = 0; i < WINDOW; i++) begin
         send_angles(ANGLE_W'(-7), ANGLE_W'(7680));
      end
      send_angles(ANGLE_W'(-7), ANGLE_W'(7681));

      write_limit('0);
      send_angles('0, '0);
      send_angles(ANGLE_W'(ANGLE_MAX), ANGLE_W'(1));
      send_angles(ANGLE_W'(-1), -ANGLE_W'(ANGLE_MAX));

      write_limit(THRESH_W'(ANGLE_MAX));
      send_angles(ANGLE_W'(ANGLE_MAX), ANGLE_W'(ANGLE_MAX));
      send_angles(ANGLE_W'(-ANGLE_MAX), -ANGLE_W'(ANGLE_MAX));
      send_angles(ANGLE_W'(12345), ANGLE_W'(-12345));

      random_phase(THRESH_W'($urandom_range(ANGLE_MAX)), 0, 0, 1'b1);
      random_phase(THRESH_W'(1), 59, 0, 1'b0);
      random_phase(THRESH_W'($urandom_range(ANGLE_MAX)), 0, 59, 1'b0);
      random_phase(THRESH_W'(ANGLE_MAX), 14, 14, 1'b0);
      random_phase(THRESH_W'($urandom_range(2000)), 0, 0, 1'b0);

      wait_drained();
      if (mismatch_count == 0 && bytes_outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
